// ----- rtl/core/rmva_pkg.sv -----
// Package for the running mean / variance accumulator.
// Widths, codes, unit request types and helper functions; no dependencies.
`timescale 1ns / 1ps
package rmva_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int COUNT_W   = 32;
  localparam int M2_W      = 63;
  localparam int FRAC_BITS = 16;
  localparam int DIFF_W    = SAMPLE_W + 1;          // |x - mean|
  localparam int MUL_A_W   = 48;                    // widest multiplicand
  localparam int MUL_B_W   = 33;
  localparam int CHUNK_W   = 16;
  localparam int MUL_STEPS = MUL_A_W / CHUNK_W;
  localparam int STEP_W    = $clog2(MUL_STEPS);
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DIV_W     = PROD_W;                // dividend width
  localparam int DSR_W     = COUNT_W + 1;           // divisor width
  localparam int ITER_W    = $clog2(DIV_W + 1);
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 192;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [M2_W-1:0]    M2_MAX    = '1;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_MERGE = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  typedef enum logic [1:0] {OP_ADD, OP_MERGE, OP_LOAD, OP_NOP} op_t;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] sample;
    logic [COUNT_W-1:0]  other_count;
    logic [SAMPLE_W-1:0] other_mean;
    logic [M2_W-1:0]     other_m2;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dvd;     // left aligned
    logic [DSR_W-1:0]  dsr;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ADD_DIV, S_ADD_SQ, S_ADD_MUL,
    S_MRG_MUL1, S_MRG_DIV1, S_MRG_MUL2, S_MRG_MUL3, S_MRG_DIV2, S_MRG_MUL4,
    S_MRG_SUM1, S_MRG_SUM2, S_VAR, S_VAR_DIV, S_OUT
  } state_t;

  function automatic logic [M2_W-1:0] sat_add(input logic [M2_W-1:0] a,
                                               input logic [M2_W-1:0] b);
    logic [M2_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[M2_W] ? M2_MAX : s[M2_W-1:0];
  endfunction

endpackage

// ----- rtl/core/rmva_front.sv -----
// Front end: takes input beats, decodes the kind and holds them in a
// two-entry queue for the sequencer. Uses rmva_pkg.
`timescale 1ns / 1ps
module rmva_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rmva_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]                    in_tuser,
  output logic                          item_valid,
  output rmva_pkg::item_t               item,
  input  logic                          item_pop
);

  rmva_pkg::item_t q_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      fill_r, fill_nxt;
  rmva_pkg::item_t dec;
  logic            push;

  always_comb begin
    case (in_tuser)
      rmva_pkg::KIND_ADD:   dec.op = rmva_pkg::OP_ADD;
      rmva_pkg::KIND_MERGE: dec.op = rmva_pkg::OP_MERGE;
      rmva_pkg::KIND_LOAD:  dec.op = rmva_pkg::OP_LOAD;
      default:              dec.op = rmva_pkg::OP_NOP;
    endcase
    dec.sample      = in_tdata[31:0];
    dec.other_count = in_tdata[63:32];
    dec.other_mean  = in_tdata[95:64];
    dec.other_m2    = in_tdata[158:96];
  end

  assign in_tready  = (fill_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign item_valid = (fill_r != 2'd0);
  assign item       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ (item_pop && item_valid);
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, item_pop && item_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ----- rtl/core/rmva_mul.sv -----
// Multi-cycle multiplier: one 16-bit slice of the multiplicand per cycle.
// Uses rmva_pkg request and response types.
`timescale 1ns / 1ps
module rmva_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  rmva_pkg::mul_req_t req,
  output rmva_pkg::mul_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [rmva_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [rmva_pkg::MUL_A_W-1:0]  a_r, a_nxt;
  logic [rmva_pkg::MUL_B_W-1:0]  b_r, b_nxt;
  logic [rmva_pkg::PROD_W-1:0]   acc_r, acc_nxt;
  logic [rmva_pkg::CHUNK_W+rmva_pkg::MUL_B_W-1:0] part;

  // top slice first, accumulator shifted up each step
  assign part = a_r[rmva_pkg::MUL_A_W-1 -: rmva_pkg::CHUNK_W] * b_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = (acc_r << rmva_pkg::CHUNK_W) + rmva_pkg::PROD_W'(part);
      a_nxt   = a_r << rmva_pkg::CHUNK_W;
      step_nxt = step_r + 1'b1;
      if (step_r == rmva_pkg::STEP_W'(rmva_pkg::MUL_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ----- rtl/core/rmva_div.sv -----
// Restoring divider, one quotient bit per cycle over a left-aligned dividend.
// Uses rmva_pkg request and response types.
`timescale 1ns / 1ps
module rmva_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rmva_pkg::div_req_t req,
  output rmva_pkg::div_rsp_t rsp
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [rmva_pkg::ITER_W-1:0]  left_r, left_nxt;
  logic [rmva_pkg::DIV_W-1:0]   dvd_r, dvd_nxt;
  logic [rmva_pkg::DIV_W-1:0]   quo_r, quo_nxt;
  logic [rmva_pkg::DSR_W-1:0]   dsr_r, dsr_nxt;
  logic [rmva_pkg::DSR_W-1:0]   rem_r, rem_nxt;
  logic [rmva_pkg::DSR_W:0]     shifted;
  logic [rmva_pkg::DSR_W+1:0]   diff;
  logic                         ge;

  assign shifted = {rem_r, dvd_r[rmva_pkg::DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};
  assign ge      = ~diff[rmva_pkg::DSR_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    left_nxt = left_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      left_nxt = req.iters;
      dvd_nxt  = req.dvd;
      dsr_nxt  = req.dsr;
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[rmva_pkg::DSR_W-1:0] : shifted[rmva_pkg::DSR_W-1:0];
      quo_nxt  = {quo_r[rmva_pkg::DIV_W-2:0], ge};
      dvd_nxt  = dvd_r << 1;
      left_nxt = left_r - 1'b1;
      if (left_r == rmva_pkg::ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
    dsr_r  <= dsr_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ----- rtl/core/rmva_exec.sv -----
// Back end: sequencer holding the accumulator state, driving the shared
// multiplier and divider, and the output register. Uses rmva_pkg,
// rmva_mul and rmva_div.
`timescale 1ns / 1ps
module rmva_exec (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_valid,
  input  rmva_pkg::item_t                 item,
  output logic                            item_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rmva_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser
);

  localparam int SW = rmva_pkg::SAMPLE_W;
  localparam int CW = rmva_pkg::COUNT_W;
  localparam int MW = rmva_pkg::M2_W;
  localparam int DW = rmva_pkg::DIFF_W;
  localparam int FB = rmva_pkg::FRAC_BITS;
  localparam int VW = rmva_pkg::DIV_W;

  rmva_pkg::state_t   state_r, state_nxt;
  rmva_pkg::item_t    item_r, item_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [SW-1:0]      mean_r, mean_nxt;
  logic [MW-1:0]      m2_r, m2_nxt;
  logic [DW-1:0]      ad_r, ad_nxt;
  logic               neg_r, neg_nxt;
  logic [DW-1:0]      tot_r, tot_nxt;
  logic [MW-1:0]      corr_r, corr_nxt;
  logic [MW-1:0]      var_r, var_nxt;
  logic               ov_r, ov_nxt;
  logic [CW-1:0]      ocnt_r, ocnt_nxt;
  logic [SW-1:0]      omean_r, omean_nxt;
  logic [MW-1:0]      om2_r, om2_nxt;
  logic [MW-1:0]      ovar_r, ovar_nxt;
  logic               ovv_r, ovv_nxt;
  logic               osat_r, osat_nxt;

  rmva_pkg::mul_req_t mreq;
  rmva_pkg::mul_rsp_t mrsp;
  rmva_pkg::div_req_t dreq;
  rmva_pkg::div_rsp_t drsp;

  logic [SW-1:0]        opnd;
  logic signed [DW-1:0] delta;
  logic [DW-1:0]        dmag;
  logic [CW-1:0]        n_add;
  logic [DW-1:0]        total;
  logic [SW+1:0]        mean_upd;
  logic                 corr_path;
  logic                 out_free;

  rmva_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  rmva_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // difference to the current mean, sample for adds, other mean for merges
  assign opnd  = (item_r.op == rmva_pkg::OP_ADD) ? item_r.sample : item_r.other_mean;
  assign delta = $signed({opnd[SW-1], opnd}) - $signed({mean_r[SW-1], mean_r});
  assign dmag  = delta[DW-1] ? DW'(-delta) : DW'(delta);
  assign n_add = (cnt_r == rmva_pkg::COUNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign total = {1'b0, cnt_r} + {1'b0, item_r.other_count};
  assign mean_upd = neg_r ? {{2{mean_r[SW-1]}}, mean_r} - {1'b0, drsp.quo[DW-1:0]}
                          : {{2{mean_r[SW-1]}}, mean_r} + {1'b0, drsp.quo[DW-1:0]};
  assign corr_path = (cnt_r != '0) && (item_r.other_count != '0);
  assign out_free  = !ov_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmva_pkg::S_IDLE:     if (item_valid) state_nxt = rmva_pkg::S_DECODE;
      rmva_pkg::S_DECODE: begin
        case (item_r.op)
          rmva_pkg::OP_ADD:   state_nxt = rmva_pkg::S_ADD_DIV;
          rmva_pkg::OP_MERGE: state_nxt = (total == '0) ? rmva_pkg::S_VAR
                                                        : rmva_pkg::S_MRG_MUL1;
          default:            state_nxt = rmva_pkg::S_VAR;
        endcase
      end
      rmva_pkg::S_ADD_DIV:  if (drsp.done) state_nxt = rmva_pkg::S_ADD_SQ;
      rmva_pkg::S_ADD_SQ:   state_nxt = rmva_pkg::S_ADD_MUL;
      rmva_pkg::S_ADD_MUL:  if (mrsp.done) state_nxt = rmva_pkg::S_VAR;
      rmva_pkg::S_MRG_MUL1: if (mrsp.done) state_nxt = rmva_pkg::S_MRG_DIV1;
      rmva_pkg::S_MRG_DIV1: begin
        if (drsp.done) begin
          state_nxt = corr_path ? rmva_pkg::S_MRG_MUL2 : rmva_pkg::S_MRG_SUM1;
        end
      end
      rmva_pkg::S_MRG_MUL2: if (mrsp.done) state_nxt = rmva_pkg::S_MRG_MUL3;
      rmva_pkg::S_MRG_MUL3: if (mrsp.done) state_nxt = rmva_pkg::S_MRG_DIV2;
      rmva_pkg::S_MRG_DIV2: if (drsp.done) state_nxt = rmva_pkg::S_MRG_MUL4;
      rmva_pkg::S_MRG_MUL4: if (mrsp.done) state_nxt = rmva_pkg::S_MRG_SUM1;
      rmva_pkg::S_MRG_SUM1: state_nxt = rmva_pkg::S_MRG_SUM2;
      rmva_pkg::S_MRG_SUM2: state_nxt = rmva_pkg::S_VAR;
      rmva_pkg::S_VAR:      state_nxt = (cnt_r >= CW'(2)) ? rmva_pkg::S_VAR_DIV
                                                          : rmva_pkg::S_OUT;
      rmva_pkg::S_VAR_DIV:  if (drsp.done) state_nxt = rmva_pkg::S_OUT;
      rmva_pkg::S_OUT:      if (out_free) state_nxt = rmva_pkg::S_IDLE;
      default:              state_nxt = rmva_pkg::S_IDLE;
    endcase
  end

  // datapath and unit requests
  always_comb begin
    item_pop  = 1'b0;
    item_nxt  = item_r;
    cnt_nxt   = cnt_r;
    mean_nxt  = mean_r;
    m2_nxt    = m2_r;
    ad_nxt    = ad_r;
    neg_nxt   = neg_r;
    tot_nxt   = tot_r;
    corr_nxt  = corr_r;
    var_nxt   = var_r;
    ov_nxt    = ov_r && !out_tready;
    ocnt_nxt  = ocnt_r;
    omean_nxt = omean_r;
    om2_nxt   = om2_r;
    ovar_nxt  = ovar_r;
    ovv_nxt   = ovv_r;
    osat_nxt  = osat_r;
    mreq      = '0;
    dreq      = '0;
    case (state_r)
      rmva_pkg::S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          item_nxt = item;
        end
      end
      rmva_pkg::S_DECODE: begin
        ad_nxt  = dmag;
        neg_nxt = delta[DW-1];
        tot_nxt = total;
        case (item_r.op)
          rmva_pkg::OP_ADD: begin
            cnt_nxt     = n_add;
            dreq.start  = 1'b1;
            dreq.dvd    = {dmag, {(VW-DW){1'b0}}};
            dreq.dsr    = {1'b0, n_add};
            dreq.iters  = rmva_pkg::ITER_W'(DW);
          end
          rmva_pkg::OP_MERGE: begin
            if (total == '0) begin
              mean_nxt = '0;
              m2_nxt   = '0;
            end else begin
              mreq.start = 1'b1;
              mreq.a     = rmva_pkg::MUL_A_W'(dmag);
              mreq.b     = rmva_pkg::MUL_B_W'(item_r.other_count);
            end
          end
          rmva_pkg::OP_LOAD: begin
            cnt_nxt  = item_r.other_count;
            mean_nxt = item_r.other_mean;
            m2_nxt   = item_r.other_m2;
          end
          default: begin
          end
        endcase
      end
      rmva_pkg::S_ADD_DIV: begin
        if (drsp.done) mean_nxt = mean_upd[SW-1:0];
      end
      rmva_pkg::S_ADD_SQ: begin
        // |x - old mean| * |x - new mean|
        mreq.start = 1'b1;
        mreq.a     = rmva_pkg::MUL_A_W'(ad_r);
        mreq.b     = rmva_pkg::MUL_B_W'(dmag);
      end
      rmva_pkg::S_ADD_MUL: begin
        if (mrsp.done) begin
          m2_nxt = rmva_pkg::sat_add(m2_r, MW'(mrsp.prod[2*SW+FB-1:FB]));
        end
      end
      rmva_pkg::S_MRG_MUL1: begin
        if (mrsp.done) begin
          dreq.start = 1'b1;
          dreq.dvd   = {mrsp.prod[2*DW-3:0], {(VW-2*DW+2){1'b0}}};
          dreq.dsr   = tot_r;
          dreq.iters = rmva_pkg::ITER_W'(2*DW-2);
        end
      end
      rmva_pkg::S_MRG_DIV1: begin
        if (drsp.done) begin
          mean_nxt = mean_upd[SW-1:0];
          if (corr_path) begin
            mreq.start = 1'b1;
            mreq.a     = rmva_pkg::MUL_A_W'(ad_r);
            mreq.b     = rmva_pkg::MUL_B_W'(ad_r);
          end else begin
            corr_nxt = '0;
          end
        end
      end
      rmva_pkg::S_MRG_MUL2: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = mrsp.prod[rmva_pkg::MUL_A_W+FB-1:FB];
          mreq.b     = rmva_pkg::MUL_B_W'(cnt_r);
        end
      end
      rmva_pkg::S_MRG_MUL3: begin
        if (mrsp.done) begin
          dreq.start = 1'b1;
          dreq.dvd   = {mrsp.prod[VW-2:0], 1'b0};
          dreq.dsr   = tot_r;
          dreq.iters = rmva_pkg::ITER_W'(VW-1);
        end
      end
      rmva_pkg::S_MRG_DIV2: begin
        if (drsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = drsp.quo[rmva_pkg::MUL_A_W-1:0];
          mreq.b     = rmva_pkg::MUL_B_W'(item_r.other_count);
        end
      end
      rmva_pkg::S_MRG_MUL4: begin
        if (mrsp.done) begin
          corr_nxt = (|mrsp.prod[rmva_pkg::PROD_W-1:MW]) ? rmva_pkg::M2_MAX
                                                         : mrsp.prod[MW-1:0];
        end
      end
      rmva_pkg::S_MRG_SUM1: begin
        m2_nxt = rmva_pkg::sat_add(m2_r, item_r.other_m2);
      end
      rmva_pkg::S_MRG_SUM2: begin
        m2_nxt  = rmva_pkg::sat_add(m2_r, corr_r);
        cnt_nxt = tot_r[DW-1] ? rmva_pkg::COUNT_MAX : tot_r[CW-1:0];
      end
      rmva_pkg::S_VAR: begin
        if (cnt_r >= CW'(2)) begin
          dreq.start = 1'b1;
          dreq.dvd   = {m2_r, {(VW-MW){1'b0}}};
          dreq.dsr   = {1'b0, cnt_r - 1'b1};
          dreq.iters = rmva_pkg::ITER_W'(MW);
        end else begin
          var_nxt = '0;
        end
      end
      rmva_pkg::S_VAR_DIV: begin
        if (drsp.done) var_nxt = drsp.quo[MW-1:0];
      end
      rmva_pkg::S_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ocnt_nxt  = cnt_r;
          omean_nxt = mean_r;
          om2_nxt   = m2_r;
          ovar_nxt  = var_r;
          ovv_nxt   = (cnt_r >= CW'(2));
          osat_nxt  = (cnt_r == rmva_pkg::COUNT_MAX) || (m2_r == rmva_pkg::M2_MAX);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmva_pkg::S_IDLE;
      cnt_r   <= '0;
      mean_r  <= '0;
      m2_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      mean_r  <= mean_nxt;
      m2_r    <= m2_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    ad_r    <= ad_nxt;
    neg_r   <= neg_nxt;
    tot_r   <= tot_nxt;
    corr_r  <= corr_nxt;
    var_r   <= var_nxt;
    ocnt_r  <= ocnt_nxt;
    omean_r <= omean_nxt;
    om2_r   <= om2_nxt;
    ovar_r  <= ovar_nxt;
    ovv_r   <= ovv_nxt;
    osat_r  <= osat_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, ovar_r, om2_r, omean_r, ocnt_r};
  assign out_tuser  = {osat_r, ovv_r};

endmodule

// ----- rtl/core/running_mean_variance_accumulator.sv -----
// Top level of the running mean / variance accumulator (Welford add,
// pairwise merge, load). Instantiates rmva_front and rmva_exec; uses rmva_pkg.
//
//  channel | dir | beat fields (low bit first)
//  in_     | in  | tuser: kind[1:0]; tdata: sample, other_count, other_mean,
//          |     |        other_m2, pad to 160
//  out_    | out | tuser: variance_valid, saturated; tdata: count, mean_out,
//          |     |        m2_out, variance, pad to 192
//
// Sequencing: the sequencer handles one beat at a time, paced by the bit-serial
//   divider and the multiplier, which works through three 16-bit slices.
//   A merge with one side empty skips the correction product and one with
//   both sides empty skips all products and quotients; the variance division
//   is skipped when the count is below two.
// Reset: rst_n synchronous, active low; clears count, mean, m2, input queue.
// Stalls: in_tready stays high until the two-beat input queue is full;
//   the output register holds a result while out_tready is low.
`timescale 1ns / 1ps
module running_mean_variance_accumulator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sample[31:0], other_count[63:32], other_mean[95:64], other_m2[158:96]
  input  logic [rmva_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // count[31:0], mean_out[63:32], m2_out[126:64], variance[189:127]
  output logic [rmva_pkg::OUT_DATA_W-1:0] out_tdata,
  // variance_valid[0], saturated[1]
  output logic [1:0]                      out_tuser
);

  logic            item_valid;
  logic            item_pop;
  rmva_pkg::item_t item;

  // front: accept and decode beats into the queue
  rmva_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  // back: state update, variance and result register
  rmva_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
